### rtl/smeu_pkg.sv
// Shared types and constants for the stack machine execute unit.
`default_nettype none
package smeu_pkg;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned VarCount = 256;
  localparam int unsigned SpW = $clog2(StackDepth + 1);
  localparam int unsigned SaW = $clog2(StackDepth);
  localparam int unsigned VaW = $clog2(VarCount);
  localparam int unsigned DepthW = 9;

  typedef enum logic [3:0] {
    OP_PUSH_INT = 4'd0, OP_PUSH_BOOL = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
    OP_MUL = 4'd4, OP_DIV = 4'd5, OP_EQ = 4'd6, OP_LT = 4'd7,
    OP_STORE = 4'd8, OP_LOAD = 4'd9, OP_JIF = 4'd10, OP_JUMP = 4'd11,
    OP_PRINT = 4'd12, OP_INPUT = 4'd13, OP_POP = 4'd14, OP_HALT = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZ = 3'd3, ST_HALT = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_ITER, S_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load_op;   // capture kind and operand
    logic         rd_top;    // read stack at sp-1 (and variable)
    logic         rd_next;   // read stack at sp-2
    logic         iter_start;
    logic         iter_step;
    logic         finish;    // commit result and strobe
  } cmd_t;

  typedef struct packed {
    logic         iter_done;
    logic         stopped;
    logic [SpW-1:0] sp;
  } stat_t;
endpackage
`default_nettype wire

### rtl/stack_machine_execute_unit_core.sv
// Top level of the stack machine execute unit.
// An item passes S_RD1, S_RD2, S_ITER (mul and div with two entries only) and S_FIN; the result is registered.
// Throughput: one item at a time; busy stays high until the result strobe cycle.
// Iteration is one bit per cycle in the shared multiply/divide unit.
// Reset empties the stack, clears variables to integer zero and resumes running.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
module stack_machine_execute_unit_core import smeu_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic start,
  output logic       busy,
  input  wire  logic [3:0] kind_i,
  input  wire  logic signed [63:0] operand_i,
  output logic       done_o,
  output logic [2:0] status_o,
  output logic       branch_taken_o,
  output logic       print_valid_o,
  output logic signed [63:0] print_value_o,
  output logic       print_is_bool_o,
  output logic [8:0] stack_depth_o
);
  cmd_t cmd;
  stat_t stat;

  smeu_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .kind_i(op_e'(kind_i)),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy)
  );

  smeu_dp u_dp (
    .clk_i, .rst_ni, .kind_i, .operand_i, .cmd_i(cmd), .stat_o(stat),
    .done_o, .status_o, .branch_taken_o, .print_valid_o,
    .print_value_o, .print_is_bool_o, .stack_depth_o
  );
endmodule
`default_nettype wire

### rtl/smeu_ctrl.sv
// Controller state machine sequencing reads, iteration and commit.
`default_nettype none
module smeu_ctrl import smeu_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic start_i,
  input  wire  op_e  kind_i,
  input  wire  stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);
  state_e state_q, state_d;
  op_e kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q <= OP_HALT;
    end else begin
      state_q <= state_d;
      kind_q <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d = kind_q;
    cmd_o = '0;
    busy_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_op = 1'b1;
          kind_d = kind_i;
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        cmd_o.rd_top = 1'b1;
        state_d = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd_next = 1'b1;
        if (!stat_i.stopped && stat_i.sp >= SpW'(2)
            && (kind_q == OP_MUL || kind_q == OP_DIV)) begin
          state_d = S_ITER;
          cmd_o.iter_start = 1'b1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ITER: begin
        cmd_o.iter_step = 1'b1;
        if (stat_i.iter_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/smeu_dp.sv
// Datapath: stack and variable memories, iterative multiply/divide, result.
`default_nettype none
module smeu_dp import smeu_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic [3:0] kind_i,
  input  wire  logic signed [63:0] operand_i,
  input  wire  cmd_t cmd_i,
  output stat_t      stat_o,
  output logic       done_o,
  output logic [2:0] status_o,
  output logic       branch_taken_o,
  output logic       print_valid_o,
  output logic signed [63:0] print_value_o,
  output logic       print_is_bool_o,
  output logic [DepthW-1:0] stack_depth_o
);
  logic [64:0] stk_mem [StackDepth];
  logic [64:0] var_mem [VarCount];
  logic [VarCount-1:0] var_vld_q;

  op_e kind_q;
  logic [63:0] opnd_q;
  logic [SpW-1:0] sp_q;
  status_e stop_q;
  logic [64:0] top_q, nxt_q, var_rd_q;
  logic [VaW-1:0] idx;
  logic [64:0] bin_res;

  // Shared iterative unit: shift-add multiply or restoring divide, 1 bit/cycle.
  logic [63:0] acc_q, quo_q, mcand_q, dvs_q;
  logic [6:0] cnt_q;
  logic neg_q;
  logic [64:0] trial;

  assign idx = VaW'(opnd_q[7:0] % VarCount);
  assign stat_o.sp = sp_q;
  assign stat_o.stopped = (stop_q != ST_OK);
  assign stat_o.iter_done = (cnt_q == 7'd63);
  assign trial = {acc_q, quo_q[63]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      kind_q <= op_e'(kind_i);
      opnd_q <= operand_i;
    end
    if (cmd_i.rd_top) begin
      top_q <= stk_mem[SaW'(sp_q - SpW'(1))];
      var_rd_q <= var_vld_q[idx] ? var_mem[idx] : 65'd0;
    end
    if (cmd_i.rd_next) nxt_q <= stk_mem[SaW'(sp_q - SpW'(2))];
    if (cmd_i.iter_start) begin
      cnt_q <= '0;
      if (kind_q == OP_MUL) begin
        acc_q <= '0;
        quo_q <= top_q[63:0];
        mcand_q <= stk_mem[SaW'(sp_q - SpW'(2))][63:0];
      end else begin
        logic [63:0] a, b;
        a = stk_mem[SaW'(sp_q - SpW'(2))][63:0];
        b = top_q[63:0];
        acc_q <= '0;
        quo_q <= a[63] ? (64'd0 - a) : a;
        dvs_q <= b[63] ? (64'd0 - b) : b;
        neg_q <= a[63] ^ b[63];
      end
    end else if (cmd_i.iter_step) begin
      cnt_q <= cnt_q + 7'd1;
      if (kind_q == OP_MUL) begin
        acc_q <= (acc_q << 1) + (quo_q[63] ? mcand_q : 64'd0);
        quo_q <= quo_q << 1;
      end else if (!trial[64]) begin
        acc_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        acc_q <= {acc_q[62:0], quo_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
    if (cmd_i.finish && stop_q == ST_OK) begin
      unique case (kind_q)
        OP_PUSH_INT, OP_INPUT:
          if (sp_q < SpW'(StackDepth)) stk_mem[SaW'(sp_q)] <= {1'b0, opnd_q};
        OP_PUSH_BOOL:
          if (sp_q < SpW'(StackDepth))
            stk_mem[SaW'(sp_q)] <= {1'b1, 63'd0, opnd_q[7:0] != 8'd0};
        OP_LOAD:
          if (sp_q < SpW'(StackDepth)) stk_mem[SaW'(sp_q)] <= var_rd_q;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT:
          if (sp_q >= SpW'(2) && !(kind_q == OP_DIV && top_q[63:0] == 64'd0))
            stk_mem[SaW'(sp_q - SpW'(2))] <= bin_res;
        OP_STORE:
          if (sp_q != '0) var_mem[idx] <= top_q;
        default: ;
      endcase
    end
  end

  always_comb begin
    bin_res = '0;
    case (kind_q)
      OP_ADD: bin_res = {1'b0, nxt_q[63:0] + top_q[63:0]};
      OP_SUB: bin_res = {1'b0, nxt_q[63:0] - top_q[63:0]};
      OP_MUL: bin_res = {1'b0, acc_q};
      OP_DIV: bin_res = {1'b0, neg_q ? (64'd0 - quo_q) : quo_q};
      OP_EQ:  bin_res = {1'b1, 63'd0, nxt_q[63:0] == top_q[63:0]};
      OP_LT:  bin_res = {1'b1, 63'd0, $signed(nxt_q[63:0]) < $signed(top_q[63:0])};
      default: bin_res = '0;
    endcase
  end

  // Commit of control state and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      stop_q <= ST_OK;
      var_vld_q <= '0;
      done_o <= 1'b0;
      status_o <= ST_OK;
      branch_taken_o <= 1'b0;
      print_valid_o <= 1'b0;
      print_value_o <= '0;
      print_is_bool_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
      if (cmd_i.finish) begin
        status_e st;
        logic [SpW-1:0] sp;
        logic br, pv;
        st = ST_OK; sp = sp_q; br = 1'b0; pv = 1'b0;
        if (stop_q != ST_OK) begin
          st = stop_q;
        end else begin
          unique case (kind_q)
            OP_PUSH_INT, OP_PUSH_BOOL, OP_LOAD, OP_INPUT:
              if (sp_q >= SpW'(StackDepth)) st = ST_OVER;
              else sp = sp_q + SpW'(1);
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT:
              if (sp_q < SpW'(2)) st = ST_UNDER;
              else if (kind_q == OP_DIV && top_q[63:0] == 64'd0) st = ST_DIVZ;
              else sp = sp_q - SpW'(1);
            OP_STORE:
              if (sp_q == '0) st = ST_UNDER;
              else var_vld_q[idx] <= 1'b1;
            OP_JIF:
              if (sp_q == '0) st = ST_UNDER;
              else br = (top_q[63:0] == 64'd0);
            OP_JUMP: br = 1'b1;
            OP_PRINT, OP_POP:
              if (sp_q == '0) st = ST_UNDER;
              else begin
                sp = sp_q - SpW'(1);
                pv = (kind_q == OP_PRINT);
              end
            default: st = ST_HALT;
          endcase
          stop_q <= st;
        end
        sp_q <= sp;
        status_o <= st;
        branch_taken_o <= br;
        print_valid_o <= pv;
        print_value_o <= pv ? top_q[63:0] : 64'd0;
        print_is_bool_o <= pv & top_q[64];
      end
    end
  end

  assign stack_depth_o = DepthW'(sp_q);
endmodule
`default_nettype wire
